FILE: rtl/hdas_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the control program of the hblank dma address sequencer
package hdas_pkg;

  localparam int DEF_NUM_CHANNELS = 4;
  localparam int DEF_MAX_UNITS    = 16;

  localparam int MAX_RESULTS = 64;
  localparam int NW          = $clog2(MAX_RESULTS + 1);
  localparam int UPL_W       = 5;
  localparam int PC_W        = 4;

  localparam logic [2:0] ACT_ARM    = 3'd0;
  localparam logic [2:0] ACT_DISARM = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_VBLANK = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_XFER = 2'd1;
  localparam logic [1:0] KIND_OVL  = 2'd2;

  localparam logic [15:0] CW_DEST_FIXED  = 16'h0040;
  localparam logic [15:0] CW_DEST_RELOAD = 16'h0060;
  localparam logic [15:0] CW_DEST_MASK   = 16'h0060;
  localparam logic [15:0] CW_SRC_FIXED   = 16'h0100;
  localparam logic [15:0] CW_WORD        = 16'h0400;

  localparam logic [2:0] BYTES_WORD = 3'd4;
  localparam logic [2:0] BYTES_HALF = 3'd2;

  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd2;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_ARM     = 4'd1;
  localparam pc_t PC_DISARM  = 4'd2;
  localparam pc_t PC_VBLANK  = 4'd3;
  localparam pc_t PC_TICK    = 4'd4;
  localparam pc_t PC_CHK_END = 4'd5;
  localparam pc_t PC_LOAD    = 4'd6;
  localparam pc_t PC_UNIT    = 4'd7;
  localparam pc_t PC_LEND    = 4'd8;
  localparam pc_t PC_NEXT    = 4'd9;
  localparam pc_t PC_TEND    = 4'd10;
  localparam pc_t PC_ACK     = 4'd11;
  localparam pc_t PC_QRY     = 4'd12;
  localparam pc_t PC_QCHK    = 4'd13;
  localparam pc_t PC_QACC    = 4'd14;
  localparam pc_t PC_QOUT    = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ARM,
    OP_DISARM,
    OP_REWIND,
    OP_KCLR,
    OP_LOAD,
    OP_UNIT,
    OP_LEND,
    OP_KINC,
    OP_ACK,
    OP_OVL,
    OP_EMIT_OVL
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_KEND,
    COND_NOT_ARMED,
    COND_NOT_ULAST,
    COND_EMITTED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    pc_t  entry;
    logic kend;
    logic not_armed;
    logic not_ulast;
    logic emitted;
  } seq_flags_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_IDLE:    w = '{OP_NONE,     COND_DISPATCH,  PC_IDLE};
      PC_ARM:     w = '{OP_ARM,      COND_ALWAYS,    PC_ACK};
      PC_DISARM:  w = '{OP_DISARM,   COND_ALWAYS,    PC_ACK};
      PC_VBLANK:  w = '{OP_REWIND,   COND_ALWAYS,    PC_ACK};
      PC_TICK:    w = '{OP_KCLR,     COND_NEXT,      PC_IDLE};
      PC_CHK_END: w = '{OP_NONE,     COND_KEND,      PC_TEND};
      PC_LOAD:    w = '{OP_LOAD,     COND_NOT_ARMED, PC_NEXT};
      PC_UNIT:    w = '{OP_UNIT,     COND_NOT_ULAST, PC_UNIT};
      PC_LEND:    w = '{OP_LEND,     COND_NEXT,      PC_IDLE};
      PC_NEXT:    w = '{OP_KINC,     COND_ALWAYS,    PC_CHK_END};
      PC_TEND:    w = '{OP_NONE,     COND_EMITTED,   PC_IDLE};
      PC_ACK:     w = '{OP_ACK,      COND_ALWAYS,    PC_IDLE};
      PC_QRY:     w = '{OP_KCLR,     COND_NEXT,      PC_IDLE};
      PC_QCHK:    w = '{OP_NONE,     COND_KEND,      PC_QOUT};
      PC_QACC:    w = '{OP_OVL,      COND_ALWAYS,    PC_QCHK};
      PC_QOUT:    w = '{OP_EMIT_OVL, COND_ALWAYS,    PC_IDLE};
      default:    w = '{OP_NONE,     COND_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(input logic [2:0] action, input logic ch_ok);
    pc_t p;
    case (action)
      ACT_ARM:    p = ch_ok ? PC_ARM : PC_ACK;
      ACT_DISARM: p = ch_ok ? PC_DISARM : PC_ACK;
      ACT_TICK:   p = PC_TICK;
      ACT_VBLANK: p = PC_VBLANK;
      ACT_QUERY:  p = PC_QRY;
      default:    p = PC_ACK;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/hdas_useq.sv
`timescale 1ns / 1ps
// step counter and control store of the sequencer with conditional jumps
module hdas_useq import hdas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  seq_flags_t flags,
  output op_t        op,
  output logic       busy
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  pc_t    pc_inc;
  ucode_t uw;

  assign uw     = ucode_rom(pc_r);
  assign pc_inc = pc_r + pc_t'(1);
  assign op     = uw.op;
  assign busy   = (pc_r != PC_IDLE);

  always_comb begin
    case (uw.cond)
      COND_NEXT:      pc_nxt = pc_inc;
      COND_ALWAYS:    pc_nxt = uw.target;
      COND_DISPATCH:  pc_nxt = start ? flags.entry : uw.target;
      COND_KEND:      pc_nxt = flags.kend ? uw.target : pc_inc;
      COND_NOT_ARMED: pc_nxt = flags.not_armed ? uw.target : pc_inc;
      COND_NOT_ULAST: pc_nxt = flags.not_ulast ? uw.target : pc_inc;
      COND_EMITTED:   pc_nxt = flags.emitted ? uw.target : pc_inc;
      default:        pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/hblank_dma_address_sequencer.sv
`timescale 1ns / 1ps
// top level: channel state, address datapath and result register of the sequencer
// arm, disarm, vblank: action step, then ack from PC_ACK; unknown actions go to PC_ACK
// line tick: per channel load, one PC_UNIT per unit if armed, next; ack if none armed
// overlap query: one channel per two steps (PC_QCHK, PC_QACC), then PC_QOUT
// next item taken in the cycle an ack or overlap result shows; the last transfer of a
//   tick is followed by PC_LEND, higher channels; one transfer per cycle, no stall
// synchronous reset disarms all channels and returns the sequencer to idle
module hblank_dma_address_sequencer import hdas_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int MAX_UNITS    = DEF_MAX_UNITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_target_address,
  input  logic [15:0] in_control_word,
  input  logic [15:0] in_unit_count,
  input  logic [7:0]  in_line_number,
  input  logic [31:0] in_query_low,
  input  logic [31:0] in_query_high,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_transfer_channel,
  output logic [31:0] out_read_address,
  output logic [31:0] out_write_address,
  output logic [2:0]  out_unit_bytes,
  output logic        out_overlap_found,
  output logic        out_any_active,
  output logic        out_last
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int KW   = $clog2(NUM_CHANNELS + 1);

  // latched transaction
  logic [1:0]  ch_r;
  logic [31:0] src_in_r;
  logic [31:0] tgt_in_r;
  logic [15:0] cw_r;
  logic [15:0] cnt_r;
  logic [7:0]  line_r;
  logic [31:0] qlo_r;
  logic [31:0] qhi_r;

  // per-channel state
  logic [NUM_CHANNELS-1:0] armed_r;
  logic [31:0]      src_org_r [NUM_CHANNELS];
  logic [31:0]      src_ptr_r [NUM_CHANNELS];
  logic [31:0]      tgt_org_r [NUM_CHANNELS];
  logic [31:0]      tgt_ptr_r [NUM_CHANNELS];
  logic [UPL_W-1:0] upl_r     [NUM_CHANNELS];
  logic             word_r    [NUM_CHANNELS];
  logic             hold_r    [NUM_CHANNELS];
  logic [1:0]       mode_r    [NUM_CHANNELS];

  // walk registers
  logic [KW-1:0]    k_r;
  logic [UPL_W-1:0] u_r;
  logic [NW-1:0]    n_r;
  logic [31:0]      dst_r;
  logic             ovl_r;

  // result register
  logic        out_strobe_r;
  logic        out_strobe_nxt;
  logic [1:0]  out_kind_r;
  logic [1:0]  out_chan_r;
  logic [31:0] out_rd_r;
  logic [31:0] out_wr_r;
  logic [2:0]  out_bytes_r;
  logic        out_ovl_r;
  logic        out_act_r;
  logic        out_last_r;

  op_t        op;
  seq_flags_t flags;
  logic       accept;
  logic       ch_ok;

  logic [CH_W-1:0]  k_idx;
  logic [CH_W-1:0]  arm_idx;
  logic [2:0]       unit_sz;
  logic             ulast;
  logic             none_above;
  logic             any_armed;
  logic [UPL_W-1:0] upl_dec;
  logic [1:0]       mode_dec;
  logic [6:0]       span;
  logic [32:0]      fp_end;
  logic             hit;

  assign accept    = start && !busy;
  assign ch_ok     = (32'(in_channel) < NUM_CHANNELS);
  assign k_idx     = k_r[CH_W-1:0];
  assign arm_idx   = CH_W'(ch_r);
  assign any_armed = |armed_r;
  assign unit_sz   = word_r[k_idx] ? BYTES_WORD : BYTES_HALF;
  assign ulast     = (u_r == upl_r[k_idx] - UPL_W'(1));
  assign none_above = (((armed_r >> k_idx) >> 1) == '0);

  assign out_strobe_nxt = ((op == OP_UNIT) && (32'(n_r) < MAX_RESULTS))
                          || (op == OP_ACK) || (op == OP_EMIT_OVL);

  assign flags.entry     = entry_pc(in_action, ch_ok);
  assign flags.kend      = (32'(k_r) == NUM_CHANNELS);
  assign flags.not_armed = !armed_r[k_idx];
  assign flags.not_ulast = !ulast;
  assign flags.emitted   = (n_r != '0);

  always_comb begin
    if (cnt_r == 16'd0) begin
      upl_dec = UPL_W'(1);
    end else if (32'(cnt_r) > MAX_UNITS) begin
      upl_dec = UPL_W'(MAX_UNITS);
    end else begin
      upl_dec = cnt_r[UPL_W-1:0];
    end
    case (cw_r & CW_DEST_MASK)
      CW_DEST_FIXED:  mode_dec = MODE_FIXED;
      CW_DEST_RELOAD: mode_dec = MODE_RELOAD;
      default:        mode_dec = MODE_INC;
    endcase
  end

  // destination footprint of the walked channel
  always_comb begin
    if (mode_r[k_idx] == MODE_FIXED) begin
      span = 7'(unit_sz);
    end else if (word_r[k_idx]) begin
      span = {upl_r[k_idx], 2'b00};
    end else begin
      span = {1'b0, upl_r[k_idx], 1'b0};
    end
    fp_end = {1'b0, tgt_org_r[k_idx]} + 33'(span);
    hit    = armed_r[k_idx] && (tgt_org_r[k_idx] < qhi_r) && (fp_end > {1'b0, qlo_r});
  end

  hdas_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= in_channel;
      src_in_r <= in_source_address;
      tgt_in_r <= in_target_address;
      cw_r     <= in_control_word;
      cnt_r    <= in_unit_count;
      line_r   <= in_line_number;
      qlo_r    <= in_query_low;
      qhi_r    <= in_query_high;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= '0;
      out_strobe_r <= 1'b0;
      k_r          <= '0;
      u_r          <= '0;
      n_r          <= '0;
      ovl_r        <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      case (op)
        OP_ARM: begin
          armed_r[arm_idx]   <= 1'b1;
          src_org_r[arm_idx] <= src_in_r;
          src_ptr_r[arm_idx] <= src_in_r;
          tgt_org_r[arm_idx] <= tgt_in_r;
          tgt_ptr_r[arm_idx] <= tgt_in_r;
          upl_r[arm_idx]     <= upl_dec;
          word_r[arm_idx]    <= ((cw_r & CW_WORD) != '0);
          hold_r[arm_idx]    <= ((cw_r & CW_SRC_FIXED) != '0);
          mode_r[arm_idx]    <= mode_dec;
        end
        OP_DISARM: begin
          armed_r[arm_idx] <= 1'b0;
        end
        OP_REWIND: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (armed_r[i]) begin
              src_ptr_r[i] <= src_org_r[i];
              tgt_ptr_r[i] <= tgt_org_r[i];
            end
          end
        end
        OP_KCLR: begin
          k_r   <= '0;
          n_r   <= '0;
          ovl_r <= 1'b0;
        end
        OP_LOAD: begin
          u_r   <= '0;
          dst_r <= tgt_ptr_r[k_idx];
        end
        OP_UNIT: begin
          if (32'(n_r) < MAX_RESULTS) begin
            out_kind_r   <= KIND_XFER;
            out_chan_r   <= 2'(k_r);
            out_rd_r     <= src_ptr_r[k_idx];
            out_wr_r     <= dst_r;
            out_bytes_r  <= unit_sz;
            out_ovl_r    <= 1'b0;
            out_act_r    <= any_armed;
            out_last_r   <= (ulast && none_above) || (32'(n_r) == MAX_RESULTS - 1);
            n_r          <= n_r + NW'(1);
          end
          if (!hold_r[k_idx]) begin
            src_ptr_r[k_idx] <= src_ptr_r[k_idx] + 32'(unit_sz);
          end
          if (mode_r[k_idx] != MODE_FIXED) begin
            dst_r <= dst_r + 32'(unit_sz);
          end
          u_r <= u_r + UPL_W'(1);
        end
        OP_LEND: begin
          if (line_r == 8'd0) begin
            src_ptr_r[k_idx] <= src_org_r[k_idx];
            tgt_ptr_r[k_idx] <= tgt_org_r[k_idx];
          end else if (mode_r[k_idx] == MODE_RELOAD) begin
            tgt_ptr_r[k_idx] <= tgt_org_r[k_idx];
          end else begin
            tgt_ptr_r[k_idx] <= dst_r;
          end
        end
        OP_KINC: begin
          k_r <= k_r + KW'(1);
        end
        OP_OVL: begin
          ovl_r <= ovl_r | hit;
          k_r   <= k_r + KW'(1);
        end
        OP_ACK, OP_EMIT_OVL: begin
          out_kind_r   <= (op == OP_EMIT_OVL) ? KIND_OVL : KIND_ACK;
          out_chan_r   <= 2'd0;
          out_rd_r     <= 32'd0;
          out_wr_r     <= 32'd0;
          out_bytes_r  <= 3'd0;
          out_ovl_r    <= (op == OP_EMIT_OVL) ? ovl_r : 1'b0;
          out_act_r    <= any_armed;
          out_last_r   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_result_kind      = out_kind_r;
  assign out_transfer_channel = out_chan_r;
  assign out_read_address     = out_rd_r;
  assign out_write_address    = out_wr_r;
  assign out_unit_bytes       = out_bytes_r;
  assign out_overlap_found    = out_ovl_r;
  assign out_any_active       = out_act_r;
  assign out_last             = out_last_r;

endmodule

FILE: rtl/hdas_checker.sv
`timescale 1ns / 1ps
// port-level checker of the sequencer and its bind to the top level
module hdas_checker import hdas_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_result_kind,
  input logic [31:0] out_read_address,
  input logic [31:0] out_write_address,
  input logic [2:0]  out_unit_bytes,
  input logic        out_last
);

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accepted transaction");

  // more results pending means the block is still busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("idle while results of a transaction are pending");

  a_xfer_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == KIND_XFER |->
      out_unit_bytes == BYTES_HALF || out_unit_bytes == BYTES_WORD)
    else $error("bad unit size on transfer");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind != KIND_XFER |->
      out_read_address == 32'd0 && out_write_address == 32'd0 && out_unit_bytes == 3'd0
      && out_last)
    else $error("non-transfer result carries address data");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("reset did not return to idle");

endmodule

bind hblank_dma_address_sequencer hdas_checker u_hdas_checker (.*);
